[sv/urm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types and fixed constants of the ultrasonic range monitor.
// ----------------------------------------------------------------------------
package urm_pkg;

  typedef enum logic {
    OpMeasure   = 1'b0,
    OpMinMaxClr = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ZoneOut     = 2'd0,
    ZoneDanger  = 2'd1,
    ZoneCaution = 2'd2,
    ZoneSafe    = 2'd3
  } zone_e;

  localparam int unsigned EchoW = 15;
  localparam int unsigned DistW = 13;
  localparam int unsigned ThrW  = 9;

  localparam logic [EchoW-1:0] EchoMaxUs  = 15'd23500;
  localparam logic [10:0]      DistMul    = 11'd1124;
  localparam logic [DistW-1:0] DistMin16  = 13'd32;
  localparam logic [DistW-1:0] DistFull16 = 13'd5600;
  localparam logic [DistW-1:0] FillBias   = 13'd28;
  localparam logic [11:0]      Recip7     = 12'd2341;

  localparam logic [ThrW-1:0]  ThrReset   = 9'd30;
  localparam logic [2:0]       TimeoutSat = 3'd7;
  localparam logic [2:0]       TimeoutLimit = 3'd5;
  localparam logic [1:0]       RecoverLimit = 2'd3;

  localparam logic [31:0] GapNear   = 32'd150;
  localparam logic [31:0] GapClose  = 32'd300;
  localparam logic [31:0] GapMedium = 32'd550;
  localparam logic [31:0] GapFar    = 32'd900;

  typedef struct packed {
    op_e              opcode;
    logic [EchoW-1:0] echo_us;
    logic [31:0]      now_ms;
  } in_word_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             reading_valid;
    zone_e            zone;
    logic [6:0]       fill_percent;
    logic             alert_active;
    logic             alert_changed;
    logic             beep_start;
    logic [DistW-1:0] min_distance;
    logic [DistW-1:0] max_distance;
    logic             minmax_valid;
    logic             sensor_missing;
    logic [31:0]      ping_count;
  } out_word_t;

  typedef logic [ThrW-1:0] cfg_word_t;

endpackage

[sv/urm_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface urm_stream_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);

endinterface

[sv/ultrasonic_range_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_monitor
// Echo-to-distance conversion, zoning, alert, beep pacing and sensor health.
// ----------------------------------------------------------------------------
// Takes one word per clock on in_s unless out_s stalls, and returns exactly
// one result word per input word on out_s, in order. A word passes through
// the input register and then the result register; both stages move every
// cycle unless out_s stalls. The alert threshold on cfg_s is always ready;
// the user must write it only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module ultrasonic_range_monitor (
  input  logic         clk_i,
  input  logic         rst_ni,
  urm_stream_if.sink   in_s,
  urm_stream_if.source out_s,
  urm_stream_if.sink   cfg_s
);

  logic                        in_valid_q;
  urm_pkg::in_word_t           in_word_q;
  logic                        out_valid_q;
  urm_pkg::out_word_t          out_word_q;
  urm_pkg::out_word_t          out_word_d;
  logic                        advance;
  logic                        fire;

  logic [urm_pkg::ThrW-1:0]    thr_q;
  logic [urm_pkg::DistW-1:0]   min_q, min_d;
  logic [urm_pkg::DistW-1:0]   max_q, max_d;
  logic                        seen_q, seen_d;
  logic                        alert_prev_q, alert_prev_d;
  logic [31:0]                 last_beep_q, last_beep_d;
  logic [2:0]                  timeout_q, timeout_d;
  logic [1:0]                  recover_q, recover_d;
  logic                        err_q, err_d;
  logic                        ever_q, ever_d;
  logic [31:0]                 ping_q, ping_d;

  logic                        is_meas;
  logic                        in_range;
  logic [25:0]                 prod;
  logic [urm_pkg::DistW-1:0]   raw;
  logic                        meas_valid;
  logic [urm_pkg::DistW-1:0]   dist_val;
  logic [14:0]                 t16, t32, t48, d4, dist15;
  logic                        alert;
  urm_pkg::zone_e              zone;
  logic [urm_pkg::DistW-1:0]   clamp;
  logic [urm_pkg::DistW-1:0]   fill_num;
  logic [21:0]                 fill_prod;
  logic [6:0]                  fill;
  logic [31:0]                 gap;
  logic [31:0]                 elapsed;
  logic                        beep;
  logic [2:0]                  timeout_inc;
  logic [1:0]                  recover_inc;

  assign advance      = !out_valid_q || out_s.ready;
  assign fire         = in_valid_q && advance;
  assign in_s.ready   = !in_valid_q || advance;
  assign cfg_s.ready  = 1'b1;
  assign out_s.valid  = out_valid_q;
  assign out_s.data   = out_word_q;

  // Distance and classification
  assign is_meas    = (in_word_q.opcode == urm_pkg::OpMeasure);
  assign in_range   = (in_word_q.echo_us != '0) && (in_word_q.echo_us <= urm_pkg::EchoMaxUs);
  assign prod       = 26'(in_word_q.echo_us) * 26'(urm_pkg::DistMul);
  assign raw        = prod[24:12];
  assign meas_valid = is_meas && in_range && (raw >= urm_pkg::DistMin16);
  assign dist_val   = meas_valid ? raw : '0;

  assign t16    = {2'b00, thr_q, 4'b0000};
  assign t32    = {1'b0, thr_q, 5'b00000};
  assign t48    = t16 + t32;
  assign dist15 = {2'b00, dist_val};
  assign d4     = {dist_val, 2'b00};
  assign alert  = meas_valid && (dist15 < t16);

  always_comb begin
    if (!meas_valid) begin
      zone = urm_pkg::ZoneOut;
    end else if (dist15 < t16) begin
      zone = urm_pkg::ZoneDanger;
    end else if (dist15 < t48) begin
      zone = urm_pkg::ZoneCaution;
    end else begin
      zone = urm_pkg::ZoneSafe;
    end
  end

  // Round half up of (5600 - c) / 56, divide by 8 then by 7 via reciprocal
  assign clamp     = (dist_val > urm_pkg::DistFull16) ? urm_pkg::DistFull16 : dist_val;
  assign fill_num  = urm_pkg::DistFull16 - clamp + urm_pkg::FillBias;
  assign fill_prod = 22'(fill_num[12:3]) * 22'(urm_pkg::Recip7);
  assign fill      = meas_valid ? fill_prod[20:14] : '0;

  always_comb begin
    if (d4 < t16) begin
      gap = urm_pkg::GapNear;
    end else if (d4 < t32) begin
      gap = urm_pkg::GapClose;
    end else if (d4 < t48) begin
      gap = urm_pkg::GapMedium;
    end else begin
      gap = urm_pkg::GapFar;
    end
  end

  assign elapsed     = in_word_q.now_ms - last_beep_q;
  assign beep        = alert && (elapsed >= gap);
  assign timeout_inc = (timeout_q != urm_pkg::TimeoutSat) ? timeout_q + 3'd1 : timeout_q;
  assign recover_inc = recover_q + 2'd1;

  always_comb begin
    min_d        = min_q;
    max_d        = max_q;
    seen_d       = seen_q;
    alert_prev_d = alert_prev_q;
    last_beep_d  = last_beep_q;
    timeout_d    = timeout_q;
    recover_d    = recover_q;
    err_d        = err_q;
    ever_d       = ever_q;
    ping_d       = ping_q;
    if (!is_meas) begin
      min_d  = '0;
      max_d  = '0;
      seen_d = 1'b0;
    end else begin
      ping_d       = ping_q + 32'd1;
      alert_prev_d = alert;
      if (beep) begin
        last_beep_d = in_word_q.now_ms;
      end
      if (!meas_valid) begin
        recover_d = '0;
        if (!ever_q) begin
          timeout_d = timeout_inc;
          if (timeout_inc >= urm_pkg::TimeoutLimit) begin
            err_d = 1'b1;
          end
        end
      end else begin
        ever_d    = 1'b1;
        timeout_d = '0;
        recover_d = '0;
        if (err_q) begin
          recover_d = recover_inc;
          if (recover_inc >= urm_pkg::RecoverLimit) begin
            err_d     = 1'b0;
            recover_d = '0;
          end
        end
        if (!seen_q || dist_val < min_q) begin
          min_d = dist_val;
        end
        if (!seen_q || dist_val > max_q) begin
          max_d = dist_val;
        end
        seen_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_word_d.distance       = dist_val;
    out_word_d.reading_valid  = meas_valid;
    out_word_d.zone           = zone;
    out_word_d.fill_percent   = fill;
    out_word_d.alert_active   = is_meas ? alert : alert_prev_q;
    out_word_d.alert_changed  = is_meas && (alert != alert_prev_q);
    out_word_d.beep_start     = beep;
    out_word_d.min_distance   = min_d;
    out_word_d.max_distance   = max_d;
    out_word_d.minmax_valid   = seen_d;
    out_word_d.sensor_missing = err_d;
    out_word_d.ping_count     = ping_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      thr_q        <= urm_pkg::ThrReset;
      min_q        <= '0;
      max_q        <= '0;
      seen_q       <= 1'b0;
      alert_prev_q <= 1'b0;
      last_beep_q  <= '0;
      timeout_q    <= '0;
      recover_q    <= '0;
      err_q        <= 1'b0;
      ever_q       <= 1'b0;
      ping_q       <= '0;
    end else begin
      if (in_s.ready) begin
        in_valid_q <= in_s.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (cfg_s.valid) begin
        thr_q <= cfg_s.data;
      end
      if (fire) begin
        min_q        <= min_d;
        max_q        <= max_d;
        seen_q       <= seen_d;
        alert_prev_q <= alert_prev_d;
        last_beep_q  <= last_beep_d;
        timeout_q    <= timeout_d;
        recover_q    <= recover_d;
        err_q        <= err_d;
        ever_q       <= ever_d;
        ping_q       <= ping_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) begin
      in_word_q <= in_s.data;
    end
    if (fire) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

[sv/urm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_checker
// Port-level checks of the range monitor, bound to the top level.
// ----------------------------------------------------------------------------
module urm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  urm_stream_if.source out_s
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && !out_s.ready |=> out_s.valid && $stable(out_s.data))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && out_s.data.reading_valid |->
      out_s.data.distance >= urm_pkg::DistMin16 && out_s.data.zone != urm_pkg::ZoneOut)
    else $error("valid reading with short distance or no zone");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && !out_s.data.reading_valid |->
      out_s.data.distance == '0 && out_s.data.fill_percent == '0 &&
      out_s.data.zone == urm_pkg::ZoneOut && !out_s.data.beep_start)
    else $error("invalid reading carries measurement fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && out_s.data.beep_start |-> out_s.data.alert_active)
    else $error("beep without alert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && out_s.data.minmax_valid |->
      out_s.data.min_distance <= out_s.data.max_distance)
    else $error("min above max");

endmodule

bind ultrasonic_range_monitor urm_checker u_urm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .out_s  (out_s)
);
